@@ sv/chacha_pkg.sv @@
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared types, constants and round functions for the ChaCha20 XOR core.
// ----------------------------------------------------------------------------
package chacha_pkg;

  localparam int ROUND_COUNT_DEF = 20;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int WORD_W          = 32;
  localparam int BYTES_PER_WORD  = 4;
  localparam int VB_W            = 3;
  localparam int IDX_W           = 4;
  localparam int CTR_W           = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int KEY_PAIRS       = 4;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY01 = 3'd0,
    CFG_KEY23 = 3'd1,
    CFG_KEY45 = 3'd2,
    CFG_KEY67 = 3'd3,
    CFG_NONCE = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_ADD,
    BK_EMIT
  } back_state_e;

  typedef logic [15:0][31:0] state_t;
  typedef logic [KEY_PAIRS-1:0][CFG_DATA_W-1:0] key_t;

  typedef struct packed {
    logic [WORD_W-1:0]         data_word;
    logic [VB_W-1:0]           valid_bytes;
    logic                      last;
    logic [BYTES_PER_WORD-1:0] byte_en;
    logic                      new_block;
    logic [IDX_W-1:0]          word_idx;
    logic [CTR_W-1:0]          counter;
  } chacha_entry_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  function automatic logic [31:0] rotl32(logic [31:0] x, int n);
    rotl32 = (x << n) | (x >> (32 - n));
  endfunction

  function automatic quad_t quarter(quad_t q);
    quad_t r;
    r = q;
    r.a = r.a + r.b; r.d = rotl32(r.d ^ r.a, 16);
    r.c = r.c + r.d; r.b = rotl32(r.b ^ r.c, 12);
    r.a = r.a + r.b; r.d = rotl32(r.d ^ r.a, 8);
    r.c = r.c + r.d; r.b = rotl32(r.b ^ r.c, 7);
    return r;
  endfunction

  // Column round when diag is low, diagonal round when high.
  function automatic state_t chacha_round(state_t s, logic diag);
    state_t r;
    quad_t  q;
    int     ib;
    int     ic;
    int     id;
    r = s;
    for (int j = 0; j < 4; j++) begin
      ib = diag ? 4 + ((j + 1) % 4) : 4 + j;
      ic = diag ? 8 + ((j + 2) % 4) : 8 + j;
      id = diag ? 12 + ((j + 3) % 4) : 12 + j;
      q = quarter('{a: s[j], b: s[ib], c: s[ic], d: s[id]});
      r[j]  = q.a;
      r[ib] = q.b;
      r[ic] = q.c;
      r[id] = q.d;
    end
    return r;
  endfunction

  function automatic state_t build_init(key_t key, logic [CTR_W-1:0] ctr,
                                        logic [CFG_DATA_W-1:0] nonce);
    state_t s;
    s[0] = SIGMA0;
    s[1] = SIGMA1;
    s[2] = SIGMA2;
    s[3] = SIGMA3;
    for (int i = 0; i < KEY_PAIRS; i++) begin
      s[4 + 2 * i] = key[i][31:0];
      s[5 + 2 * i] = key[i][63:32];
    end
    s[12] = ctr[31:0];
    s[13] = ctr[63:32];
    s[14] = nonce[31:0];
    s[15] = nonce[63:32];
    return s;
  endfunction

endpackage

@@ sv/chacha_front.sv @@
// ----------------------------------------------------------------------------
// chacha_front
// Accepts data words, tracks word index and block counter, tags each request.
// ----------------------------------------------------------------------------
module chacha_front import chacha_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [WORD_W-1:0]     data_word_i,
  input  logic [VB_W-1:0]       valid_bytes_i,
  input  logic                  message_start_i,
  input  logic                  message_end_i,
  input  logic                  full_i,
  output logic                  push_o,
  output chacha_entry_t         entry_o
);

  logic [IDX_W-1:0] idx_q, idx_d, idx_cur;
  logic [CTR_W-1:0] ctr_q, ctr_d, ctr_cur;
  logic [VB_W-1:0]  vb_clamp;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    idx_cur  = message_start_i ? '0 : idx_q;
    ctr_cur  = message_start_i ? '0 : ctr_q;
    vb_clamp = (valid_bytes_i > VB_W'(BYTES_PER_WORD)) ? VB_W'(BYTES_PER_WORD)
                                                       : valid_bytes_i;
    entry_o.data_word   = data_word_i;
    entry_o.valid_bytes = valid_bytes_i;
    entry_o.last        = message_end_i;
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      entry_o.byte_en[b] = vb_clamp > VB_W'(b);
    end
    entry_o.new_block = (idx_cur == '0);
    entry_o.word_idx  = idx_cur;
    entry_o.counter   = ctr_cur;
    idx_d = idx_q;
    ctr_d = ctr_q;
    if (push_o) begin
      idx_d = idx_cur + 1'b1;
      ctr_d = (idx_cur == '1) ? ctr_cur + 1'b1 : ctr_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ctr_q <= '0;
    end else begin
      idx_q <= idx_d;
      ctr_q <= ctr_d;
    end
  end

endmodule

@@ sv/chacha_fifo.sv @@
// ----------------------------------------------------------------------------
// chacha_fifo
// Short first-word-fall-through queue between front and back.
// ----------------------------------------------------------------------------
module chacha_fifo import chacha_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  chacha_entry_t entry_i,
  output logic          full_o,
  input  logic          pop_i,
  output chacha_entry_t head_o,
  output logic          empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  chacha_entry_t    mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ sv/chacha_back.sv @@
// ----------------------------------------------------------------------------
// chacha_back
// Runs the block rounds, holds the keystream block, XORs and registers output.
// ----------------------------------------------------------------------------
module chacha_back import chacha_pkg::*; #(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  key_t                  key_i,
  input  logic [CFG_DATA_W-1:0] nonce_i,
  input  chacha_entry_t         head_i,
  input  logic                  head_valid_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [WORD_W-1:0]     cipher_word_o,
  output logic [VB_W-1:0]       out_valid_bytes_o,
  output logic                  out_last_o
);

  localparam int RoundsEff = ((ROUND_COUNT + 1) / 2) * 2;
  localparam int RndW      = $clog2(RoundsEff);

  back_state_e       state_q, state_d;
  logic [RndW-1:0]   rnd_q;
  state_t            work_q;
  state_t            init;
  logic [31:0]       ks_q [16];
  logic              out_free, emit, load_init, do_round, do_add;
  logic [WORD_W-1:0] ks_word, mask;

  assign init     = build_init(key_i, head_i.counter, nonce_i);
  assign out_free = !out_valid_o || !out_stall_i;
  assign pop_o    = emit;
  assign ks_word  = ks_q[head_i.word_idx];

  always_comb begin
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      mask[8*b +: 8] = {8{head_i.byte_en[b]}};
    end
  end

  always_comb begin
    state_d   = state_q;
    emit      = 1'b0;
    load_init = 1'b0;
    do_round  = 1'b0;
    do_add    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          if (head_i.new_block) begin
            load_init = 1'b1;
            state_d   = BK_ROUND;
          end else if (out_free) begin
            emit = 1'b1;
          end
        end
      end
      BK_ROUND: begin
        do_round = 1'b1;
        if (rnd_q == RndW'(RoundsEff - 1)) begin
          state_d = BK_ADD;
        end
      end
      BK_ADD: begin
        do_add  = 1'b1;
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rnd_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_init) begin
        rnd_q <= '0;
      end else if (do_round) begin
        rnd_q <= rnd_q + 1'b1;
      end
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_init) begin
      work_q <= init;
    end else if (do_round) begin
      work_q <= chacha_round(work_q, rnd_q[0]);
    end
    if (do_add) begin
      for (int i = 0; i < 16; i++) begin
        ks_q[i] <= work_q[i] + init[i];
      end
    end
    if (emit) begin
      cipher_word_o     <= (head_i.data_word ^ ks_word) & mask;
      out_valid_bytes_o <= head_i.valid_bytes;
      out_last_o        <= head_i.last;
    end
  end

endmodule

@@ sv/chacha20_stream_xor_core.sv @@
// ----------------------------------------------------------------------------
// chacha20_stream_xor_core: ChaCha20 keystream XOR, one 32-bit word per request
// The first word of a block waits for the block rounds, one round per cycle, and
// then the feed-forward add; later words of the block use the held keystream.
// The queue keeps accepting words while the rounds run, until it is full.
// Reset clears counter, word index, queue, output valid and key/nonce registers.
// ----------------------------------------------------------------------------
module chacha20_stream_xor_core import chacha_pkg::*; #(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [WORD_W-1:0]     data_word_i,
  input  logic [VB_W-1:0]       valid_bytes_i,
  input  logic                  message_start_i,
  input  logic                  message_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [WORD_W-1:0]     cipher_word_o,
  output logic [VB_W-1:0]       out_valid_bytes_o,
  output logic                  out_last_o
);

  key_t                  key_q;
  logic [CFG_DATA_W-1:0] nonce_q;
  logic                  push, full, pop, empty;
  chacha_entry_t         entry, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      nonce_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_KEY01: key_q[0] <= cfg_data_i;
        CFG_KEY23: key_q[1] <= cfg_data_i;
        CFG_KEY45: key_q[2] <= cfg_data_i;
        CFG_KEY67: key_q[3] <= cfg_data_i;
        CFG_NONCE: nonce_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  chacha_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .data_word_i,
    .valid_bytes_i,
    .message_start_i,
    .message_end_i,
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  chacha_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  chacha_back #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_back (
    .clk_i,
    .rst_ni,
    .key_i        (key_q),
    .nonce_i      (nonce_q),
    .head_i       (head),
    .head_valid_i (!empty),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .cipher_word_o,
    .out_valid_bytes_o,
    .out_last_o
  );

endmodule

@@ sv/chacha_checker.sv @@
// ----------------------------------------------------------------------------
// chacha_checker
// Port-level checks on the output channel of the ChaCha20 XOR core.
// ----------------------------------------------------------------------------
module chacha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] cipher_word_o,
  input logic [2:0]  out_valid_bytes_o,
  input logic        out_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cipher_word_o)
      && $stable(out_valid_bytes_o) && $stable(out_last_o))
    else $error("stalled result changed");

  a_zero_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_valid_bytes_o == 3'd0 |-> cipher_word_o == 32'd0)
    else $error("word with no valid bytes is not zero");

  a_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_valid_bytes_o == 3'd1 |-> cipher_word_o[31:8] == 24'd0)
    else $error("bytes above one valid byte not zero");

  a_two_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_valid_bytes_o == 3'd2 |-> cipher_word_o[31:16] == 16'd0)
    else $error("bytes above two valid bytes not zero");

  a_three_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_valid_bytes_o == 3'd3 |-> cipher_word_o[31:24] == 8'd0)
    else $error("byte above three valid bytes not zero");

endmodule

bind chacha20_stream_xor_core chacha_checker u_checker (.*);

@@ test/tb_chacha20_stream_xor_core.sv @@
// ----------------------------------------------------------------------------
// tb_chacha20_stream_xor_core: regression for the ChaCha20 stream XOR core
// A queue of word requests feeds a clocked driver. A clocked monitor checks
// every cipher word against a ChaCha20 keystream predictor that tracks
// counter and word index. Both sides idle at random. Key and nonce change
// between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_xor_core;
  import chacha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 216;
  localparam int QUIET_LIMIT    = 2000;
  localparam int MAX_REPORTS    = 50;

  typedef struct {
    logic [WORD_W-1:0] data;
    logic [VB_W-1:0]   nbytes;
    logic              start;
    logic              stop;
    bit                drain_first;
  } word_req_t;

  typedef struct {
    logic [WORD_W-1:0] cipher;
    logic [VB_W-1:0]   nbytes;
    logic              last;
  } cipher_exp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [WORD_W-1:0]     data_word_i = '0;
  logic [VB_W-1:0]       valid_bytes_i = '0;
  logic                  message_start_i = 1'b0;
  logic                  message_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [WORD_W-1:0]     cipher_word_o;
  logic [VB_W-1:0]       out_valid_bytes_o;
  logic                  out_last_o;

  chacha20_stream_xor_core uut (.*);

  word_req_t   word_req_q[$];
  cipher_exp_t cipher_expected_q[$];

  logic [KEY_PAIRS-1:0][63:0] key_sh = '0;
  logic [63:0]                nonce_sh = '0;
  logic [63:0]                ks_counter = '0;
  logic [3:0]                 ks_index = '0;
  logic [15:0][31:0]          ks_words = '0;

  int n_queued = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_fail = 0;
  int idle_mode = 0;
  int send_gap = 0;
  int recv_hold = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [15:0][31:0] mix_quarter(input logic [15:0][31:0] s,
                                                    input int a, input int b,
                                                    input int c, input int d);
    s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 7);
    return s;
  endfunction

  function automatic logic [15:0][31:0] chacha_block(input logic [63:0] ctr);
    logic [15:0][31:0] init;
    logic [15:0][31:0] s;
    init[0] = SIGMA0;
    init[1] = SIGMA1;
    init[2] = SIGMA2;
    init[3] = SIGMA3;
    for (int k = 0; k < KEY_PAIRS; k++) begin
      init[4 + 2 * k] = key_sh[k][31:0];
      init[5 + 2 * k] = key_sh[k][63:32];
    end
    init[12] = ctr[31:0];
    init[13] = ctr[63:32];
    init[14] = nonce_sh[31:0];
    init[15] = nonce_sh[63:32];
    s = init;
    for (int r = 0; r < ROUND_COUNT_DEF; r += 2) begin
      s = mix_quarter(s, 0, 4, 8, 12);
      s = mix_quarter(s, 1, 5, 9, 13);
      s = mix_quarter(s, 2, 6, 10, 14);
      s = mix_quarter(s, 3, 7, 11, 15);
      s = mix_quarter(s, 0, 5, 10, 15);
      s = mix_quarter(s, 1, 6, 11, 12);
      s = mix_quarter(s, 2, 7, 8, 13);
      s = mix_quarter(s, 3, 4, 9, 14);
    end
    for (int k = 0; k < 16; k++) s[k] = s[k] + init[k];
    return s;
  endfunction

  function automatic void chacha_apply(input word_req_t r);
    cipher_exp_t e;
    logic [31:0] mask;
    logic [31:0] ks;
    if (r.start) begin
      ks_counter = '0;
      ks_index = '0;
    end
    if (ks_index == 4'd0) ks_words = chacha_block(ks_counter);
    ks = ks_words[ks_index];
    ks_index = ks_index + 4'd1;
    if (ks_index == 4'd0) ks_counter = ks_counter + 64'd1;
    mask = (r.nbytes >= 3'd4) ? 32'hffff_ffff : ((32'd1 << (8 * r.nbytes)) - 32'd1);
    e.cipher = (r.data ^ ks) & mask;
    e.nbytes = r.nbytes;
    e.last = r.stop;
    cipher_expected_q.push_back(e);
  endfunction

  function automatic int draw_wait();
    case (idle_mode)
      1: return $urandom_range(0, 14);
      2: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
      default: return 0;
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (n_fail < MAX_REPORTS)
        $display("%0t: %s expected %08h actual %08h", $time, what, want, got);
      n_fail++;
    end
  endfunction

  function automatic void push_req(input logic [31:0] data, input logic [2:0] nbytes,
                                   input logic start, input logic stop,
                                   input bit drain_first);
    word_req_t r;
    r.data = data;
    r.nbytes = nbytes;
    r.start = start;
    r.stop = stop;
    r.drain_first = drain_first;
    word_req_q.push_back(r);
    n_queued++;
  endfunction

  function automatic int add_message();
    int  len;
    bit  with_start;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 70) : $urandom_range(1, 20);
    with_start = $urandom_range(0, 9) != 0;
    for (int k = 0; k < len; k++)
      push_req($urandom, (k == len - 1) ? 3'($urandom_range(1, 4)) : 3'd4,
               with_start && k == 0, k == len - 1, $urandom_range(0, 149) == 0);
    return len;
  endfunction

  function automatic void queue_directed();
    push_req(32'h0000_0000, 3'd4, 1'b1, 1'b0, 1'b0);
    push_req(32'hffff_ffff, 3'd4, 1'b0, 1'b0, 1'b0);
    push_req(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 1'b0);
    push_req(32'hffff_ffff, 3'd1, 1'b0, 1'b0, 1'b0);
    push_req(32'hffff_ffff, 3'd2, 1'b0, 1'b0, 1'b0);
    push_req(32'hffff_ffff, 3'd3, 1'b0, 1'b0, 1'b0);
    push_req(32'hffff_ffff, 3'd5, 1'b0, 1'b0, 1'b0);
    push_req(32'hffff_ffff, 3'd6, 1'b0, 1'b0, 1'b0);
    push_req(32'hffff_ffff, 3'd7, 1'b0, 1'b0, 1'b0);
    push_req(32'ha5a5_a5a5, 3'd4, 1'b0, 1'b1, 1'b0);
    push_req(32'h5a5a_5a5a, 3'd4, 1'b0, 1'b0, 1'b1);
    for (int k = 0; k < 8; k++)
      push_req($urandom, 3'd4, 1'b0, k == 7, 1'b0);
    push_req(32'h1234_5678, 3'd2, 1'b1, 1'b1, 1'b0);
    push_req(32'hffff_ffff, 3'd4, 1'b1, 1'b0, 1'b0);
    push_req(32'h0000_0000, 3'd0, 1'b1, 1'b1, 1'b0);
    push_req(32'h8000_0001, 3'd7, 1'b1, 1'b1, 1'b0);
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_KEY01: key_sh[0] = val;
      CFG_KEY23: key_sh[1] = val;
      CFG_KEY45: key_sh[2] = val;
      CFG_KEY67: key_sh[3] = val;
      CFG_NONCE: nonce_sh = val;
      default: ;
    endcase
  endtask

  task automatic load_keys(input logic [63:0] k01, input logic [63:0] k23,
                           input logic [63:0] k45, input logic [63:0] k67,
                           input logic [63:0] nonce);
    write_reg(CFG_KEY01, k01);
    write_reg(CFG_KEY23, k23);
    write_reg(CFG_KEY45, k45);
    write_reg(CFG_KEY67, k67);
    write_reg(CFG_NONCE, nonce);
  endtask

  task automatic wait_idle();
    while (!(n_sent == n_queued && n_checked == n_queued)) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    word_req_t nxt;
    word_req_t cur;
    int        sent_now;
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      data_word_i     <= '0;
      valid_bytes_i   <= '0;
      message_start_i <= 1'b0;
      message_end_i   <= 1'b0;
      send_gap        <= 0;
      n_sent          <= 0;
    end else begin
      sent_now = n_sent;
      if (in_valid_i && !in_stall_o) begin
        cur.data = data_word_i;
        cur.nbytes = valid_bytes_i;
        cur.start = message_start_i;
        cur.stop = message_end_i;
        cur.drain_first = 1'b0;
        chacha_apply(cur);
        sent_now = n_sent + 1;
        n_sent <= sent_now;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (word_req_q.size() > 0 &&
                     !(word_req_q[0].drain_first && sent_now != n_checked)) begin
          nxt = word_req_q.pop_front();
          data_word_i     <= nxt.data;
          valid_bytes_i   <= nxt.nbytes;
          message_start_i <= nxt.start;
          message_end_i   <= nxt.stop;
          in_valid_i      <= 1'b1;
          send_gap        <= draw_wait();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_words
    cipher_exp_t want;
    int          hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_hold   <= 0;
      n_checked   <= 0;
    end else begin
      hold = recv_hold;
      if (out_valid_o && !out_stall_i) begin
        n_checked <= n_checked + 1;
        hold = draw_wait();
        if (cipher_expected_q.size() == 0) begin
          if (n_fail < MAX_REPORTS)
            $display("%0t: unexpected cipher word expected none actual %08h",
                     $time, cipher_word_o);
          n_fail++;
        end else begin
          want = cipher_expected_q.pop_front();
          check_field("cipher_word", want.cipher, cipher_word_o);
          check_field("out_valid_bytes", 32'(want.nbytes), 32'(out_valid_bytes_o));
          check_field("out_last", 32'(want.last), 32'(out_last_o));
        end
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        recv_hold   <= hold - 1;
      end else begin
        out_stall_i <= 1'b0;
        recv_hold   <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("chacha20_stream_xor_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int total;
    queue_directed();
    total = 0;
    while (total < ITEMS_PER_PHASE) begin
      if ($urandom_range(0, 99) < 85) begin
        total += add_message();
      end else begin
        push_req($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'b0);
        total++;
      end
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 1; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        1: load_keys('1, '1, '1, '1, '1);
        3: load_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, '1);
        4: load_keys('1, '1, '1, '1, '0);
        6: load_keys('0, '0, '0, '0, {$urandom, $urandom});
        default: load_keys({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom});
      endcase
      @(negedge clk_i);
      idle_mode = ph % 3;
      total = 0;
      while (total < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 85) begin
          total += add_message();
        end else begin
          push_req($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'b0);
          total++;
        end
      end
    end
    wait_idle();
    repeat (4 * ROUND_COUNT_DEF) @(posedge clk_i);
    if (cipher_expected_q.size() != 0) begin
      $display("%0t: cipher words outstanding expected 0 actual %0d",
               $time, cipher_expected_q.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("chacha20_stream_xor_core regression: pass");
    end else begin
      $display("chacha20_stream_xor_core regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/chacha_pkg.sv
sv/chacha_front.sv
sv/chacha_fifo.sv
sv/chacha_back.sv
sv/chacha20_stream_xor_core.sv
sv/chacha_checker.sv
test/tb_chacha20_stream_xor_core.sv
